FILE: rtl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

    localparam int WRAM_BYTES_DEF = 16384;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int ROM_AW   = 17;
    localparam int OFF_W    = 13;
    localparam int BANK_W   = 4;

    // Address windows
    localparam logic [ADDR_W-1:0] LOW_WIN_LO   = 16'h6000;
    localparam logic [ADDR_W-1:0] LOW_WIN_HI   = 16'h7FFF;
    localparam logic [ADDR_W-1:0] HIGH_WIN_LO  = 16'hB800;
    localparam logic [ADDR_W-1:0] HIGH_WIN_HI  = 16'hD7FF;
    localparam logic [ADDR_W-1:0] BANK_WIN_LO  = 16'h8000;
    localparam logic [ADDR_W-1:0] BANK_WIN_HI  = 16'h8FFF;
    localparam logic [ADDR_W-1:0] MIRR_WIN_LO  = 16'hE000;
    localparam logic [ADDR_W-1:0] MIRR_WIN_HI  = 16'hEFFF;
    localparam logic [ADDR_W-1:0] MODE_WIN_LO  = 16'hF000;
    localparam logic [ADDR_W-1:0] ROM_WIN_LO   = 16'h8000;

    // Upper work RAM half starts here
    localparam int HIGH_WRAM_BASE = 32'h2000;

    // Fixed banks start at bank C
    localparam logic [1:0] FIXED_BANK_TOP = 2'b11;

    localparam int MIRROR_BIT_POS = 3;
    localparam int MODE_BIT_POS   = 4;

    typedef enum logic
    {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } req_type_t;

    // Result fields decided at decode time
    typedef struct packed
    {
        logic              rom_hit;
        logic [ROM_AW-1:0] rom_addr;
        logic              wram_hit;
        logic              wram_rd;
        logic              mirror_select;
    } access_t;

endpackage

`default_nettype wire

FILE: rtl/cbm_ram.sv
`default_nettype none

module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cbm_decode.sv
`default_nettype none

module cbm_decode #(
    parameter int WRAM_BYTES = cbm_pkg::WRAM_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          req_type,
    input  wire logic [cbm_pkg::ADDR_W-1:0]    addr,
    input  wire logic [cbm_pkg::DATA_W-1:0]    wdata,
    output logic                               ram_en,
    output logic                               ram_we,
    output logic [$clog2(WRAM_BYTES)-1:0]      ram_addr,
    output cbm_pkg::access_t                   access
);

    localparam int WRAM_AW = $clog2(WRAM_BYTES);

    logic [cbm_pkg::BANK_W-1:0] prg_bank_reg;
    logic [cbm_pkg::BANK_W-1:0] prg_bank_next;
    logic                       mirror_bit_reg;
    logic                       mirror_bit_next;
    logic                       rom_mode_reg;
    logic                       rom_mode_next;

    logic                       is_write;
    logic                       low_win;
    logic                       high_win;
    logic [cbm_pkg::OFF_W-1:0]  off;
    logic [cbm_pkg::ADDR_W-1:0] high_diff;
    logic [WRAM_AW-1:0]         low_index;
    logic [WRAM_AW-1:0]         high_index;

    always_comb
    begin
        is_write  = (req_type == cbm_pkg::REQ_WRITE);
        low_win   = (addr >= cbm_pkg::LOW_WIN_LO) && (addr <= cbm_pkg::LOW_WIN_HI);
        high_win  = (addr >= cbm_pkg::HIGH_WIN_LO) && (addr <= cbm_pkg::HIGH_WIN_HI);
        off       = addr[cbm_pkg::OFF_W-1:0];
        high_diff = addr - cbm_pkg::HIGH_WIN_LO;
        low_index = WRAM_AW'(off);
        high_index = WRAM_AW'(cbm_pkg::HIGH_WRAM_BASE + 32'(high_diff[cbm_pkg::OFF_W-1:0]));
    end

    // Mapper register updates
    always_comb
    begin
        prg_bank_next   = prg_bank_reg;
        mirror_bit_next = mirror_bit_reg;
        rom_mode_next   = rom_mode_reg;
        if (is_write && !low_win && !high_win)
        begin
            if ((addr >= cbm_pkg::BANK_WIN_LO) && (addr <= cbm_pkg::BANK_WIN_HI))
            begin
                prg_bank_next = wdata[cbm_pkg::BANK_W-1:0];
            end
            else if ((addr >= cbm_pkg::MIRR_WIN_LO) && (addr <= cbm_pkg::MIRR_WIN_HI))
            begin
                mirror_bit_next = wdata[cbm_pkg::MIRROR_BIT_POS];
            end
            else if (addr >= cbm_pkg::MODE_WIN_LO)
            begin
                rom_mode_next = wdata[cbm_pkg::MODE_BIT_POS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_reg   <= '0;
            mirror_bit_reg <= 1'b0;
            rom_mode_reg   <= 1'b0;
        end
        else if (accept)
        begin
            prg_bank_reg   <= prg_bank_next;
            mirror_bit_reg <= mirror_bit_next;
            rom_mode_reg   <= rom_mode_next;
        end
    end

    // Access decode and RAM port control
    always_comb
    begin
        access.rom_hit       = 1'b0;
        access.rom_addr      = '0;
        access.wram_hit      = 1'b0;
        access.wram_rd       = 1'b0;
        access.mirror_select = ~mirror_bit_next;
        ram_addr             = low_win ? low_index : high_index;

        if (is_write)
        begin
            access.wram_hit = low_win || high_win;
        end
        else if (low_win)
        begin
            if (rom_mode_reg)
            begin
                access.rom_hit  = 1'b1;
                access.rom_addr = {prg_bank_reg, off};
            end
            else
            begin
                access.wram_hit = 1'b1;
                access.wram_rd  = 1'b1;
            end
        end
        else if (addr >= cbm_pkg::ROM_WIN_LO)
        begin
            if (!rom_mode_reg && high_win)
            begin
                access.wram_hit = 1'b1;
                access.wram_rd  = 1'b1;
            end
            else
            begin
                access.rom_hit  = 1'b1;
                access.rom_addr = {cbm_pkg::FIXED_BANK_TOP, addr[14:13], off};
            end
        end

        ram_en = accept && access.wram_hit;
        ram_we = is_write;
    end

endmodule

`default_nettype wire

FILE: rtl/cartridge_bank_mapper_with_wram_top.sv
// An accepted transaction is decoded into stage 1, then moves to the output register driving m_*.
// One transaction per cycle unless m_* stalls; the single work RAM port does one access a cycle.
// A stalled output holds the pipeline; s_tready stays high while the output register can drain.
// Reset (rst_n, asynchronous, active low) clears the bank, mirroring and mode registers and
// all valid flags; work RAM contents are undefined until written.
`default_nettype none

module cartridge_bank_mapper_with_wram_top #(
    parameter int WRAM_BYTES = cbm_pkg::WRAM_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] addr, [23:16] wdata
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [16:0] rom_addr, [24:17] read_data,
                                        // [25] mirror_select, [31:26] zero
    output logic [1:0]       m_tuser    // [0] rom_hit, [1] wram_hit
);

    localparam int WRAM_AW = $clog2(WRAM_BYTES);

    logic                        accept;
    logic                        ram_en;
    logic                        ram_we;
    logic [WRAM_AW-1:0]          ram_addr;
    logic [cbm_pkg::DATA_W-1:0]  ram_rdata;
    cbm_pkg::access_t            access;

    // Stage 1: RAM access in flight
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    cbm_pkg::access_t            s1_reg;
    logic                        s1_advance;

    // Stage 2: output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    cbm_pkg::access_t            out_reg;
    logic [cbm_pkg::DATA_W-1:0]  out_rdata_reg;

    // Advance stage 1 whenever the output register is empty or draining.
    // The RAM read register only updates on a new read, so a stalled
    // stage 1 keeps its data.
    assign s1_advance = !out_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign accept     = s_tvalid && s_tready;

    cbm_decode #(
        .WRAM_BYTES (WRAM_BYTES)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (s_tuser),
        .addr     (s_tdata[15:0]),
        .wdata    (s_tdata[23:16]),
        .ram_en   (ram_en),
        .ram_we   (ram_we),
        .ram_addr (ram_addr),
        .access   (access)
    );

    cbm_ram #(
        .WIDTH (cbm_pkg::DATA_W),
        .DEPTH (WRAM_BYTES)
    ) u_wram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata[23:16]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_valid_reg && s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture decode on accept, move to output when stage 1 advances
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= access;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_reg       <= s1_reg;
            out_rdata_reg <= s1_reg.wram_rd ? ram_rdata : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.mirror_select, out_rdata_reg, out_reg.rom_addr};
    assign m_tuser  = {out_reg.wram_hit, out_reg.rom_hit};

endmodule

`default_nettype wire

FILE: rtl/cbm_checker.sv
`default_nettype none

module cbm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Never hit ROM and work RAM at once
    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("rom_hit and wram_hit both set");

    // Drop ROM address when not a ROM read
    a_rom_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[16:0] == 17'd0)
        else $error("rom_addr nonzero without rom_hit");

    // Read data is zero unless work RAM was hit
    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[24:17] == 8'd0)
        else $error("read_data nonzero without wram_hit");

    // An empty pipeline never refuses a transaction
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("input stalled with empty pipeline");

endmodule

bind cartridge_bank_mapper_with_wram_top cbm_checker u_cbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
